FILE: rtl/hbhm_pkg.sv
`default_nettype none

package hbhm_pkg;

  localparam int NODES_DEFAULT = 2;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_EPISODE_LIMIT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FAULT_HOLD_MS = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_STABLE_MS     = 2'd2;

  localparam logic [7:0]  EPISODE_LIMIT_RST = 8'd3;
  localparam logic [15:0] FAULT_HOLD_MS_RST = 16'd5000;
  localparam logic [15:0] STABLE_MS_RST     = 16'd3000;

  localparam logic [1:0] HB_UNCONF  = 2'd0;
  localparam logic [1:0] HB_UNKNOWN = 2'd1;
  localparam logic [1:0] HB_ACTIVE  = 2'd2;
  localparam logic [1:0] HB_TIMEOUT = 2'd3;

  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    H_UNCONF  = 3'd0,
    H_UNKNOWN = 3'd1,
    H_ACTIVE  = 3'd2,
    H_TIMEOUT = 3'd3,
    H_FAULT   = 3'd4,
    H_RECOVER = 3'd5
  } health_t;

  typedef struct packed {
    logic [1:0]  seen_state;
    logic [1:0]  earlier_state;
    logic [31:0] change_time;
    logic [31:0] fault_start;
    logic [31:0] recovery_start;
    logic        fault_open;
    logic [15:0] episode_count;
    logic [15:0] recovery_count;
    logic [31:0] recovery_duration;
    health_t     health_code;
    health_t     earlier_health;
  } rec_t;

endpackage

`default_nettype wire

FILE: rtl/heartbeat_health_monitor_unit.sv
`default_nettype none

// Channel  Handshake                  Payload
// -------  -------------------------  ------------------------------------------
// item     item_valid / item_stall    node_index, hb_state, now_ms
// result   result_valid / result_stall health, prev_health, prev_hb_state,
//                                     fault_active, timeout_episodes, recoveries,
//                                     last_recovery_ms, last_change_ms
// cfg      cfg_wr_en                  cfg_index, cfg_data
//
// One item per cycle sustained while result_stall is low; each item passes the input
// register, then the result register. The node record read-modify-write sits between
// the two registers, so reports for the same node may follow each other every cycle.
// Synchronous reset clears all node records and loads the register defaults.
// A stalled result holds the result register; the input register then holds
// and item_stall rises once it is occupied.

module heartbeat_health_monitor_unit #(
  parameter int NODES = hbhm_pkg::NODES_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst,

  input  wire logic                             cfg_wr_en,
  input  wire logic [hbhm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [hbhm_pkg::CFG_DATA_W-1:0]  cfg_data,

  input  wire logic                             item_valid,
  output logic                                  item_stall,
  input  wire logic                             node_index,
  input  wire logic [1:0]                       hb_state,
  input  wire logic [31:0]                      now_ms,

  output logic                                  result_valid,
  input  wire logic                             result_stall,
  output logic [2:0]                            health,
  output logic [2:0]                            prev_health,
  output logic [1:0]                            prev_hb_state,
  output logic                                  fault_active,
  output logic [15:0]                           timeout_episodes,
  output logic [15:0]                           recoveries,
  output logic [31:0]                           last_recovery_ms,
  output logic [31:0]                           last_change_ms
);

  localparam int IDX_W = (NODES > 1) ? $clog2(NODES) : 1;

  logic [7:0]  episode_limit;
  logic [15:0] fault_hold_ms;
  logic [15:0] stable_ms;

  hbhm_pkg::rec_t recs [NODES];

  logic        s1_valid;
  logic        s1_node;
  logic [1:0]  s1_state;
  logic [31:0] s1_now;

  logic           s1_advance;
  logic [IDX_W-1:0] sel;
  logic           in_range;
  hbhm_pkg::rec_t cur;
  hbhm_pkg::rec_t rec_next;
  logic           changed;

  always_ff @(posedge clk) begin
    if (rst) begin
      episode_limit <= hbhm_pkg::EPISODE_LIMIT_RST;
      fault_hold_ms <= hbhm_pkg::FAULT_HOLD_MS_RST;
      stable_ms     <= hbhm_pkg::STABLE_MS_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        hbhm_pkg::REG_EPISODE_LIMIT: episode_limit <= cfg_data[7:0];
        hbhm_pkg::REG_FAULT_HOLD_MS: fault_hold_ms <= cfg_data[15:0];
        hbhm_pkg::REG_STABLE_MS:     stable_ms     <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // advance the input register when the result register is free or being taken
  assign s1_advance = !result_valid || !result_stall;
  assign item_stall = s1_valid && !s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!item_stall) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!item_stall && item_valid) begin
      s1_node  <= node_index;
      s1_state <= hb_state;
      s1_now   <= now_ms;
    end
  end

  assign sel      = IDX_W'(s1_node);
  assign in_range = (32'(s1_node) < 32'(NODES));
  assign cur      = recs[sel];
  assign changed  = (s1_state != cur.seen_state);

  always_comb begin
    rec_next            = cur;
    rec_next.seen_state = s1_state;
    if (changed) begin
      rec_next.earlier_state = cur.seen_state;
      rec_next.change_time   = s1_now;
      if (s1_state == hbhm_pkg::HB_TIMEOUT) begin
        rec_next.fault_start    = s1_now;
        rec_next.recovery_start = 32'd0;
        rec_next.fault_open     = 1'b1;
        if (cur.episode_count != hbhm_pkg::COUNT_MAX) begin
          rec_next.episode_count = cur.episode_count + 16'd1;
        end
      end else if (cur.fault_open && s1_state == hbhm_pkg::HB_ACTIVE) begin
        rec_next.recovery_duration = s1_now - cur.fault_start;
        if (cur.recovery_count != hbhm_pkg::COUNT_MAX) begin
          rec_next.recovery_count = cur.recovery_count + 16'd1;
        end
        rec_next.fault_start = 32'd0;
        rec_next.fault_open  = 1'b0;
      end
    end

    case (s1_state)
      hbhm_pkg::HB_UNCONF:  rec_next.health_code = hbhm_pkg::H_UNCONF;
      hbhm_pkg::HB_UNKNOWN: rec_next.health_code = hbhm_pkg::H_UNKNOWN;
      hbhm_pkg::HB_TIMEOUT: begin
        if ((rec_next.episode_count >= {8'd0, episode_limit}) ||
            (rec_next.fault_open &&
             ((s1_now - rec_next.fault_start) >= {16'd0, fault_hold_ms}))) begin
          rec_next.health_code = hbhm_pkg::H_FAULT;
        end else begin
          rec_next.health_code = hbhm_pkg::H_TIMEOUT;
        end
      end
      default: begin
        if (rec_next.earlier_state == hbhm_pkg::HB_TIMEOUT &&
            cur.health_code != hbhm_pkg::H_RECOVER &&
            rec_next.recovery_start == 32'd0) begin
          rec_next.recovery_start = s1_now;
          rec_next.health_code    = hbhm_pkg::H_RECOVER;
        end else if (cur.health_code == hbhm_pkg::H_RECOVER &&
                     ((s1_now - rec_next.recovery_start) >= {16'd0, stable_ms})) begin
          rec_next.health_code = hbhm_pkg::H_ACTIVE;
        end else if (cur.health_code != hbhm_pkg::H_RECOVER &&
                     cur.health_code != hbhm_pkg::H_ACTIVE) begin
          rec_next.health_code = hbhm_pkg::H_ACTIVE;
        end
      end
    endcase

    if (rec_next.health_code != cur.health_code) begin
      rec_next.earlier_health = cur.health_code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int n = 0; n < NODES; n++) begin
        recs[n] <= '0;
      end
    end else if (s1_valid && s1_advance && in_range) begin
      recs[sel] <= rec_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_advance) begin
      result_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_advance) begin
      if (in_range) begin
        health           <= rec_next.health_code;
        prev_health      <= rec_next.earlier_health;
        prev_hb_state    <= rec_next.earlier_state;
        fault_active     <= rec_next.fault_open;
        timeout_episodes <= rec_next.episode_count;
        recoveries       <= rec_next.recovery_count;
        last_recovery_ms <= rec_next.recovery_duration;
        last_change_ms   <= rec_next.change_time;
      end else begin
        health           <= 3'd0;
        prev_health      <= 3'd0;
        prev_hb_state    <= 2'd0;
        fault_active     <= 1'b0;
        timeout_episodes <= 16'd0;
        recoveries       <= 16'd0;
        last_recovery_ms <= 32'd0;
        last_change_ms   <= 32'd0;
      end
    end
  end

endmodule

`default_nettype wire
